// File: rtl/core/tgt_pkg.sv
// ----------------------------------------------------------------------------
// tgt_pkg: shared types and constants of the text group tokenizer
// Run kinds, group type codes, configuration register indexes and the
// per-byte result word passed from the front end to the output side.
// ----------------------------------------------------------------------------
package tgt_pkg;

	localparam int RES_MAX   = 3;      // results one byte can cause
	localparam int QDEPTH    = 4;      // words in the front/back queue
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int RIDX_W    = $clog2(RES_MAX);

	localparam logic [15:0] POS_MAX = 16'hFFFF;   // offsets saturate here

	typedef enum logic [1:0] {
		KIND_NONE    = 2'd0,
		KIND_PRINT   = 2'd1,
		KIND_NEWLINE = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		GT_ALPHA   = 3'd0,
		GT_NUMERIC = 3'd1,
		GT_NEWLINE = 3'd2,
		GT_MIXED   = 3'd3,
		GT_EOM     = 3'd4
	} group_type_t;

	typedef enum logic {
		CFG_MAX_GROUP_LEN    = 1'b0,
		CFG_NUL_ENDS_MESSAGE = 1'b1
	} cfg_index_t;

	typedef struct packed {
		group_type_t gtype;
		logic [15:0] start;
		logic [7:0]  length;
	} result_t;

	// all results of one byte, in delivery order
	typedef struct packed {
		logic [RIDX_W-1:0]          count;
		result_t [RES_MAX-1:0]      res;
	} bundle_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic group_type_t group_code(input kind_t kind, input logic alpha,
			input logic digit);
		group_type_t code;
		if (kind == KIND_NEWLINE) begin
			code = GT_NEWLINE;
		end else if (alpha) begin
			code = GT_ALPHA;
		end else if (digit) begin
			code = GT_NUMERIC;
		end else begin
			code = GT_MIXED;
		end
		return code;
	endfunction

endpackage

// File: rtl/core/text_group_tokenizer.sv
// ----------------------------------------------------------------------------
// text_group_tokenizer: streaming whitespace tokenizer with group typing
// Splits a byte stream into printable and CR/LF groups and reports each
// group's type, start offset and length, then an end-of-message word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one byte per unstalled cycle with
// data_byte and last_byte. The front end classifies the byte and updates the
// open run in the cycle it is accepted, then queues the zero to three results
// the byte causes as one word; bytes that cause nothing are absorbed.
// Output channel (out_valid/out_stall) delivers one result per unstalled cycle
// from a registered output; last_of_run marks the final result of its byte.
// Results are queued as the byte is accepted, then loaded into the output
// register. Unstalled throughput: 1 byte per cycle in, 1 result per cycle
// out; bytes that make several results are limited by the single output port.
// A stalled receiver holds the output word; the 4-word queue then fills and
// in_stall rises. Config writes (cfg_we/cfg_index/cfg_data) apply at once.
// Reset clears the run state and offset, sets max_group_len to 255 and
// nul_ends_message to 1, and empties the queue.
// ----------------------------------------------------------------------------
module text_group_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  group_type,
	output logic [15:0] group_start,
	output logic [7:0]  group_length,
	output logic        last_of_run
);

	tgt_pkg::bundle_t push_word;
	tgt_pkg::bundle_t head;
	tgt_pkg::qstat_t  stat;
	logic             push;
	logic             pop;
	logic             accept;

	assign in_stall = stat.full;
	assign accept   = in_valid && !stat.full;

	tgt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.push_word (push_word)
	);

	tgt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	tgt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.stat         (stat),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.group_type   (group_type),
		.group_start  (group_start),
		.group_length (group_length),
		.last_of_run  (last_of_run)
	);

endmodule

// File: rtl/core/tgt_front.sv
// ----------------------------------------------------------------------------
// tgt_front: byte classifier and run tracker
// Classifies each accepted byte, tracks the open group and produces the
// word of results (up to three) the byte causes. Holds the config registers.
// ----------------------------------------------------------------------------
module tgt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             last_byte,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	output logic             push,
	output tgt_pkg::bundle_t push_word
);

	logic [7:0]      max_len_q;
	logic            nul_end_q;
	tgt_pkg::kind_t  kind_q;
	logic [7:0]      len_q;
	logic [15:0]     start_q;
	logic [15:0]     pos_q;
	logic            alpha_q;
	logic            digit_q;

	tgt_pkg::kind_t  kind_d;
	logic [7:0]      len_d;
	logic [15:0]     start_d;
	logic [15:0]     pos_d;
	logic            alpha_d;
	logic            digit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'd255;
			nul_end_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (tgt_pkg::cfg_index_t'(cfg_index))
				tgt_pkg::CFG_MAX_GROUP_LEN:    max_len_q <= cfg_data;
				tgt_pkg::CFG_NUL_ENDS_MESSAGE: nul_end_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tgt_pkg::kind_t   cls;
		tgt_pkg::bundle_t w;
		logic [tgt_pkg::RIDX_W-1:0] cnt;
		logic [7:0] limit;
		logic is_alpha;
		logic is_digit;
		logic ending;

		cls = tgt_pkg::KIND_NONE;
		if (data_byte >= 8'h21 && data_byte <= 8'h7F) begin
			cls = tgt_pkg::KIND_PRINT;
		end else if (data_byte == 8'h0A || data_byte == 8'h0D) begin
			cls = tgt_pkg::KIND_NEWLINE;
		end
		is_alpha = (data_byte >= 8'h41 && data_byte <= 8'h5A) || data_byte == 8'h3F;
		is_digit = data_byte >= 8'h30 && data_byte <= 8'h39;
		limit    = (max_len_q == 8'd0) ? 8'd1 : max_len_q;
		ending   = last_byte || (data_byte == 8'd0 && nul_end_q);

		w   = '0;
		cnt = '0;

		kind_d  = kind_q;
		len_d   = len_q;
		start_d = start_q;
		alpha_d = alpha_q;
		digit_d = digit_q;

		// byte of another run kind (or a separator) closes the open group
		if (kind_q != tgt_pkg::KIND_NONE && kind_q != cls) begin
			w.res[cnt] = '{tgt_pkg::group_code(kind_q, alpha_q, digit_q), start_q, len_q};
			cnt = cnt + 1'b1;
			kind_d = tgt_pkg::KIND_NONE;
		end

		if (cls != tgt_pkg::KIND_NONE) begin
			if (kind_d == tgt_pkg::KIND_NONE) begin
				kind_d  = cls;
				start_d = pos_q;
				len_d   = 8'd0;
				alpha_d = 1'b1;
				digit_d = 1'b1;
			end
			len_d   = len_d + 8'd1;
			alpha_d = alpha_d & is_alpha;
			digit_d = digit_d & is_digit;
			if (len_d >= limit) begin
				w.res[cnt] = '{tgt_pkg::group_code(kind_d, alpha_d, digit_d), start_d, len_d};
				cnt = cnt + 1'b1;
				kind_d = tgt_pkg::KIND_NONE;
			end
		end

		pos_d = (pos_q != tgt_pkg::POS_MAX) ? pos_q + 16'd1 : pos_q;

		if (ending) begin
			if (kind_d != tgt_pkg::KIND_NONE) begin
				w.res[cnt] = '{tgt_pkg::group_code(kind_d, alpha_d, digit_d), start_d, len_d};
				cnt = cnt + 1'b1;
			end
			w.res[cnt] = '{tgt_pkg::GT_EOM, pos_q, 8'd0};
			cnt = cnt + 1'b1;
			kind_d = tgt_pkg::KIND_NONE;
			pos_d  = 16'd0;
		end

		// a closed run returns to its reset values
		if (kind_d == tgt_pkg::KIND_NONE) begin
			len_d   = 8'd0;
			start_d = 16'd0;
			alpha_d = 1'b1;
			digit_d = 1'b1;
		end

		w.count   = cnt;
		push_word = w;
		push      = accept && (cnt != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= tgt_pkg::KIND_NONE;
			len_q   <= 8'd0;
			start_q <= 16'd0;
			pos_q   <= 16'd0;
			alpha_q <= 1'b1;
			digit_q <= 1'b1;
		end else if (accept) begin
			kind_q  <= kind_d;
			len_q   <= len_d;
			start_q <= start_d;
			pos_q   <= pos_d;
			alpha_q <= alpha_d;
			digit_q <= digit_d;
		end
	end

endmodule

// File: rtl/core/tgt_queue.sv
// ----------------------------------------------------------------------------
// tgt_queue: short queue of result words
// Decouples the byte classifier from the output side.
// ----------------------------------------------------------------------------
module tgt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tgt_pkg::bundle_t push_word,
	input  logic             pop,
	output tgt_pkg::bundle_t head,
	output tgt_pkg::qstat_t  stat
);

	tgt_pkg::bundle_t mem_q [tgt_pkg::QDEPTH];
	logic [tgt_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [tgt_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [tgt_pkg::QPTR_W:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == (tgt_pkg::QPTR_W + 1)'(tgt_pkg::QDEPTH));

endmodule

// File: rtl/core/tgt_back.sv
// ----------------------------------------------------------------------------
// tgt_back: result sequencer and output register
// Walks the results of the word at the queue head, one per unstalled cycle, into
// the output register.
// ----------------------------------------------------------------------------
module tgt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tgt_pkg::bundle_t head,
	input  tgt_pkg::qstat_t  stat,
	output logic             pop,
	input  logic             out_stall,
	output logic             out_valid,
	output logic [2:0]       group_type,
	output logic [15:0]      group_start,
	output logic [7:0]       group_length,
	output logic             last_of_run
);

	logic [tgt_pkg::RIDX_W-1:0] idx_q;
	logic                       valid_q;
	tgt_pkg::result_t           res_q;
	logic                       fin_q;

	logic                       load;
	logic                       fin;

	assign load = !stat.empty && (!valid_q || !out_stall);
	assign fin  = (idx_q == head.count - 1'b1);
	assign pop  = load && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= fin ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= head.res[idx_q];
			fin_q <= fin;
		end
	end

	assign out_valid    = valid_q;
	assign group_type   = res_q.gtype;
	assign group_start  = res_q.start;
	assign group_length = res_q.length;
	assign last_of_run  = fin_q;

endmodule
